/* src/bsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_pkg
// Types and constants for the boot and reset sequencer: the phase encoding,
// register indexes and register reset values.
// ----------------------------------------------------------------------------
package bsr_pkg;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_BRIDGE   = 4'd1,
		PH_BSETTLE  = 4'd2,
		PH_RSETTLE  = 4'd3,
		PH_HOLD     = 4'd4,
		PH_RELEASE  = 4'd5,
		PH_DL_BOOT  = 4'd6,
		PH_DL_EN    = 4'd7,
		PH_SHORT_EN = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		REG_LONG_PRESS    = 2'd0,
		REG_POLL_PERIOD   = 2'd1,
		REG_ENABLE_SETTLE = 2'd2,
		REG_BOOT_SETTLE   = 2'd3
	} reg_index_t;

	localparam int unsigned WAIT_W   = 10;
	localparam int unsigned CFG_W    = 10;
	localparam int unsigned PRESS_W  = 8;
	localparam int unsigned SETTLE_W = 8;

	localparam logic [PRESS_W-1:0]  LONG_PRESS_RST    = 8'd15;
	localparam logic [WAIT_W-1:0]   POLL_PERIOD_RST   = 10'd100;
	localparam logic [SETTLE_W-1:0] ENABLE_SETTLE_RST = 8'd10;
	localparam logic [SETTLE_W-1:0] BOOT_SETTLE_RST   = 8'd5;
	localparam logic [PRESS_W-1:0]  PRESS_MAX         = 8'd255;

	// A wait length of zero behaves as one tick.
	function automatic logic [WAIT_W-1:0] at_least_one(input logic [WAIT_W-1:0] v);
		at_least_one = (v == '0) ? WAIT_W'(1) : v;
	endfunction

endpackage

/* src/boot_reset_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boot_reset_sequencer
// Drives a target's enable and boot-strap pins from serial RTS/DTR lines and
// a reset button, one tick transaction in and one pin transaction out.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           contents
//  s_axis    in         s_tvalid/s_tready   one tick: rts, dtr, button
//  m_axis    out        m_tvalid/m_tready   pin levels after that tick
//  cfg       in         cfg_valid/cfg_ready register index and value
//
// For each tick transaction, the sequencer state and the
// result register update at the edge that accepts it. A tick is accepted
// whenever the result register is empty or being taken in the same cycle, so
// a stalled output holds one result and stops input only while it stays full.
// Reset leaves the target released and the registers at their defaults.
// ----------------------------------------------------------------------------
module boot_reset_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // rts_active, dtr_active, button_down, zeros
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,   // enable_level, boot_level, boot_driven,
	                                               // in_bridge_mode, zeros
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [bsr_pkg::CFG_W-1:0]   cfg_data
);
	import bsr_pkg::*;

	logic [PRESS_W-1:0]  long_press_q;
	logic [WAIT_W-1:0]   poll_period_q;
	logic [SETTLE_W-1:0] enable_settle_q;
	logic [SETTLE_W-1:0] boot_settle_q;

	phase_t             phase_q, phase_d;
	logic [WAIT_W-1:0]  wait_q, wait_d;
	logic [PRESS_W-1:0] press_q, press_d;
	logic               bridge_q, bridge_d;
	logic               enable_q, enable_d;
	logic               boot_q, boot_d;
	logic               drive_q, drive_d;

	logic               out_valid_q;
	logic [7:0]         out_data_q;
	logic [7:0]         result;

	logic               rts, dtr, btn;
	logic               accept;
	logic               done;
	logic [PRESS_W-1:0] press_inc;
	logic [WAIT_W-1:0]  poll_wait, en_wait, boot_wait;

	assign rts = s_tdata[0];
	assign dtr = s_tdata[1];
	assign btn = s_tdata[2];

	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	assign done      = (wait_q <= WAIT_W'(1));
	assign press_inc = (press_q == PRESS_MAX) ? press_q : press_q + PRESS_W'(1);
	assign poll_wait = at_least_one(poll_period_q);
	assign en_wait   = at_least_one(WAIT_W'(enable_settle_q));
	assign boot_wait = at_least_one(WAIT_W'(boot_settle_q));

	// Next state for one tick.
	always_comb begin
		phase_d  = phase_q;
		wait_d   = done ? '0 : wait_q - WAIT_W'(1);
		press_d  = press_q;
		bridge_d = bridge_q;
		enable_d = enable_q;
		boot_d   = boot_q;
		drive_d  = drive_q;
		case (phase_q)
			PH_BSETTLE: begin
				if (done) begin
					enable_d = 1'b0;
					drive_d  = 1'b1;
					phase_d  = PH_BRIDGE;
				end
			end
			PH_RSETTLE: begin
				if (done) begin
					drive_d = 1'b1;
					boot_d  = 1'b0;
					press_d = '0;
					wait_d  = poll_wait;
					phase_d = btn ? PH_HOLD : PH_RELEASE;
				end
			end
			PH_HOLD: begin
				if (done) begin
					press_d = press_inc;
					if (press_inc > long_press_q && !press_inc[0])
						boot_d = !boot_q;
					wait_d  = poll_wait;
					phase_d = btn ? PH_HOLD : PH_RELEASE;
				end
			end
			PH_RELEASE: begin
				if (done) begin
					if (press_q > long_press_q) begin
						boot_d  = 1'b0;
						wait_d  = boot_wait;
						phase_d = PH_DL_BOOT;
					end else begin
						boot_d  = 1'b1;
						drive_d = 1'b0;
						wait_d  = en_wait;
						phase_d = PH_SHORT_EN;
					end
				end
			end
			PH_DL_BOOT: begin
				if (done) begin
					enable_d = 1'b1;
					wait_d   = en_wait;
					phase_d  = PH_DL_EN;
				end
			end
			PH_DL_EN: begin
				if (done) begin
					boot_d  = 1'b1;
					drive_d = 1'b0;
					phase_d = PH_IDLE;
				end
			end
			PH_SHORT_EN: begin
				if (done) begin
					enable_d = 1'b1;
					phase_d  = PH_IDLE;
				end
			end
			PH_BRIDGE: begin
				wait_d = wait_q;
				if (rts || dtr) begin
					enable_d = !rts;
					boot_d   = !dtr;
					drive_d  = 1'b1;
				end else begin
					bridge_d = 1'b0;
					enable_d = 1'b1;
					boot_d   = 1'b1;
					drive_d  = 1'b0;
					phase_d  = PH_IDLE;
				end
			end
			default: begin
				// Idle, and any code that is not a phase, which first releases the pins.
				wait_d = wait_q;
				if (phase_q != PH_IDLE) begin
					enable_d = 1'b1;
					boot_d   = 1'b1;
					drive_d  = 1'b0;
					bridge_d = 1'b0;
					wait_d   = '0;
					phase_d  = PH_IDLE;
				end
				if (rts) begin
					bridge_d = 1'b1;
					enable_d = 1'b0;
					boot_d   = !dtr;
					drive_d  = 1'b0;
					wait_d   = en_wait;
					phase_d  = PH_BSETTLE;
				end else if (!dtr && btn) begin
					enable_d = 1'b0;
					wait_d   = en_wait;
					phase_d  = PH_RSETTLE;
				end
			end
		endcase
	end

	// Pin levels seen after the tick; boot reads high while released.
	always_comb begin
		result    = '0;
		result[0] = enable_d;
		result[1] = drive_d ? boot_d : 1'b1;
		result[2] = drive_d;
		result[3] = bridge_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			wait_q   <= '0;
			press_q  <= '0;
			bridge_q <= 1'b0;
			enable_q <= 1'b1;
			boot_q   <= 1'b1;
			drive_q  <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			wait_q   <= wait_d;
			press_q  <= press_d;
			bridge_q <= bridge_d;
			enable_q <= enable_d;
			boot_q   <= boot_d;
			drive_q  <= drive_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q    <= LONG_PRESS_RST;
			poll_period_q   <= POLL_PERIOD_RST;
			enable_settle_q <= ENABLE_SETTLE_RST;
			boot_settle_q   <= BOOT_SETTLE_RST;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_LONG_PRESS:    long_press_q    <= cfg_data[PRESS_W-1:0];
				REG_POLL_PERIOD:   poll_period_q   <= cfg_data[WAIT_W-1:0];
				REG_ENABLE_SETTLE: enable_settle_q <= cfg_data[SETTLE_W-1:0];
				REG_BOOT_SETTLE:   boot_settle_q   <= cfg_data[SETTLE_W-1:0];
				default: ;
			endcase
		end
	end

endmodule
